// File: design/bca_pkg.sv
`default_nettype none

package bca_pkg;

  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int THR_W  = 17;
  localparam int CFG_W  = 17;
  localparam int IDX_W  = 3;
  localparam int P_W    = 17;
  localparam int T_W    = 15;
  localparam int DT_W   = 26;
  localparam int MB_W   = 18;
  localparam int PROD_W = DT_W + MB_W;
  localparam int OFF_W  = 35;
  localparam int SENS_W = 35;
  localparam int ACC_W  = 60;
  localparam int STEP_W = 4;

  localparam logic [THR_W-1:0] THR_RESET = 17'd200;

  localparam int TEMP_BASE = 2000;
  localparam int T_MIN     = -16384;
  localparam int T_MAX     = 16383;
  localparam int P_MAX     = 131071;

  // Scale factors of the compensation, as shift counts.
  localparam int SH_REF      = 8;
  localparam int SH_TEMP     = 23;
  localparam int SH_OFF      = 7;
  localparam int SH_SENS     = 8;
  localparam int SH_OFF_CAL  = 16;
  localparam int SH_SENS_CAL = 15;
  localparam int SH_SENS_HI  = 17;
  localparam int SH_PROD     = 21;
  localparam int SH_PRES     = 15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DT,
    OP_TEMP,
    OP_OFF,
    OP_SENS,
    OP_ACC_LOAD,
    OP_ACC_ADD_HI,
    OP_ACC_SCALE,
    OP_ACC_SUB_OFF,
    OP_PRES,
    OP_DIFF,
    OP_ZERO
  } op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DT_C6,
    MUL_DT_C4,
    MUL_DT_C3,
    MUL_D1_SLO,
    MUL_D1_SHI
  } mul_t;

  typedef enum logic {
    JMP_NONE,
    JMP_NO_REQ
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS,
    REG_OFFSET,
    REG_SENS_TC,
    REG_OFFSET_TC,
    REG_REF_TEMP,
    REG_TEMP_COEFF,
    REG_THRESHOLD
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    mul_t              mul;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    mul_t mul;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] offset;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] offset_tc;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coeff;
    logic [THR_W-1:0] thr;
  } cal_t;

  // Arithmetic shift right that rounds toward zero, like signed C division by 2^k.
  function automatic logic signed [ACC_W-1:0] trunc_shr(input logic signed [ACC_W-1:0] x,
                                                        input int unsigned k);
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] sum;
    bias = '0;
    if (x[ACC_W-1]) begin
      bias = (ACC_W'(1) << k) - ACC_W'(1);
    end
    sum = x + bias;
    return sum >>> k;
  endfunction

endpackage

`default_nettype wire

// File: design/baro_compensate_autozero_unit.sv
`default_nettype none

// First-order barometric compensation with an auto-zero baseline. Each request
// carries one raw pressure and one raw temperature conversion; the block returns
// pressure in pascals, temperature in hundredths of a degree, the absolute
// difference from the stored baseline and a flag telling whether this sample
// became the new baseline. One request is processed at a time, and the next
// request is accepted only after the result of the last one has been handed to
// the output register. The microprogram runs all products through one shared
// 26x18 multiplier. The finished result sits in an output register, so the next
// request can be accepted while it waits. Calibration words are to be written
// through the cfg_ port only while the block is idle; the user is bound to this,
// the block itself does not enforce it. cfg_ready is always high.
module baro_compensate_autozero_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [bca_pkg::RAW_W-1:0]           in_raw_pressure,
  input  wire logic [bca_pkg::RAW_W-1:0]           in_raw_temperature,
  input  wire logic                                in_zero_request,
  input  wire logic                                in_zero_force,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [bca_pkg::P_W-1:0]                  out_pressure_pa,
  output logic signed [bca_pkg::T_W-1:0]           out_temperature_centi,
  output logic [bca_pkg::P_W-1:0]                  out_pressure_delta,
  output logic                                     out_baseline_renewed,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bca_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [bca_pkg::CFG_W-1:0]           cfg_data
);

  bca_pkg::cal_t                       cal_r;
  bca_pkg::dp_ctrl_t                   ctrl;
  logic                                busy;
  logic                                done;
  logic                                in_accept;
  logic                                out_free;
  logic                                req;
  logic                                out_valid_r;
  logic [bca_pkg::P_W-1:0]             dp_pressure;
  logic signed [bca_pkg::T_W-1:0]      dp_temp;
  logic [bca_pkg::P_W-1:0]             dp_delta;
  logic                                dp_renewed;
  logic [bca_pkg::P_W-1:0]             out_pressure_r;
  logic signed [bca_pkg::T_W-1:0]      out_temp_r;
  logic [bca_pkg::P_W-1:0]             out_delta_r;
  logic                                out_renewed_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, bca_pkg::THR_RESET};
    end else if (cfg_valid) begin
      case (bca_pkg::reg_idx_t'(cfg_index))
        bca_pkg::REG_SENS:       cal_r.sens       <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_OFFSET:     cal_r.offset     <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_SENS_TC:    cal_r.sens_tc    <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_OFFSET_TC:  cal_r.offset_tc  <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_REF_TEMP:   cal_r.ref_temp   <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_TEMP_COEFF: cal_r.temp_coeff <= cfg_data[bca_pkg::CAL_W-1:0];
        bca_pkg::REG_THRESHOLD:  cal_r.thr        <= cfg_data[bca_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bca_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .req      (req),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .done     (done)
  );

  bca_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (in_accept),
    .raw_pressure      (in_raw_pressure),
    .raw_temperature   (in_raw_temperature),
    .zero_request      (in_zero_request),
    .zero_force        (in_zero_force),
    .cal               (cal_r),
    .ctrl              (ctrl),
    .req               (req),
    .pressure_pa       (dp_pressure),
    .temperature_centi (dp_temp),
    .pressure_delta    (dp_delta),
    .baseline_renewed  (dp_renewed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_pressure_r <= dp_pressure;
      out_temp_r     <= dp_temp;
      out_delta_r    <= dp_delta;
      out_renewed_r  <= dp_renewed;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pressure_pa       = out_pressure_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_delta    = out_delta_r;
  assign out_baseline_renewed  = out_renewed_r;

  // An accepted request keeps the input side closed while the program runs.
  assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> in_stall)
    else $error("input not stalled after accepting a request");

  // A finished result is never dropped: completion always presents it.
  assert property (@(posedge clk) disable iff (!rst_n) done |=> out_valid)
    else $error("completed result not presented");

  // Completion only happens when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n) done |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while output stalled");

  // A renewed baseline always reports a zero difference.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_baseline_renewed) |-> (out_pressure_delta == '0))
    else $error("renewed baseline with nonzero delta");

endmodule

`default_nettype wire

// File: design/bca_ucode_rom.sv
`default_nettype none

module bca_ucode_rom (
  input  wire logic [bca_pkg::STEP_W-1:0] step,
  output bca_pkg::ucode_t                 word
);

  localparam logic [bca_pkg::STEP_W-1:0] STEP_FINISH = 4'd13;

  // The multiplier result is registered, so each step that uses a product takes
  // the one that the step before it started.
  always_comb begin
    case (step)
      4'd0:  word = '{bca_pkg::OP_DT,          bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd1:  word = '{bca_pkg::OP_NOP,         bca_pkg::MUL_DT_C6,  bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd2:  word = '{bca_pkg::OP_TEMP,        bca_pkg::MUL_DT_C4,  bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd3:  word = '{bca_pkg::OP_OFF,         bca_pkg::MUL_DT_C3,  bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd4:  word = '{bca_pkg::OP_SENS,        bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd5:  word = '{bca_pkg::OP_NOP,         bca_pkg::MUL_D1_SLO, bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd6:  word = '{bca_pkg::OP_ACC_LOAD,    bca_pkg::MUL_D1_SHI, bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd7:  word = '{bca_pkg::OP_ACC_ADD_HI,  bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd8:  word = '{bca_pkg::OP_ACC_SCALE,   bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd9:  word = '{bca_pkg::OP_ACC_SUB_OFF, bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd10: word = '{bca_pkg::OP_PRES,        bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      4'd11: word = '{bca_pkg::OP_DIFF,        bca_pkg::MUL_NONE,   bca_pkg::JMP_NO_REQ,
                      STEP_FINISH, 1'b0};
      4'd12: word = '{bca_pkg::OP_ZERO,        bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                      STEP_FINISH, 1'b0};
      default: word = '{bca_pkg::OP_NOP,       bca_pkg::MUL_NONE,   bca_pkg::JMP_NONE,
                        STEP_FINISH, 1'b1};
    endcase
  end

endmodule

`default_nettype wire

// File: design/bca_datapath.sv
`default_nettype none

module bca_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [bca_pkg::RAW_W-1:0]     raw_pressure,
  input  wire logic [bca_pkg::RAW_W-1:0]     raw_temperature,
  input  wire logic                          zero_request,
  input  wire logic                          zero_force,
  input  wire bca_pkg::cal_t                 cal,
  input  wire bca_pkg::dp_ctrl_t             ctrl,
  output logic                               req,
  output logic [bca_pkg::P_W-1:0]            pressure_pa,
  output logic signed [bca_pkg::T_W-1:0]     temperature_centi,
  output logic [bca_pkg::P_W-1:0]            pressure_delta,
  output logic                               baseline_renewed
);

  localparam int ACC_W  = bca_pkg::ACC_W;
  localparam int PROD_W = bca_pkg::PROD_W;
  localparam int OFF_W  = bca_pkg::OFF_W;

  logic [bca_pkg::RAW_W-1:0]          d1_r;
  logic [bca_pkg::RAW_W-1:0]          d2_r;
  logic                               req_r;
  logic                               force_r;
  logic signed [bca_pkg::DT_W-1:0]    dt_r;
  logic signed [PROD_W-1:0]           prod_r;
  logic signed [bca_pkg::T_W-1:0]     temp_r;
  logic signed [OFF_W-1:0]            off_r;
  logic signed [bca_pkg::SENS_W-1:0]  sens_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic [bca_pkg::P_W-1:0]            p_r;
  logic [bca_pkg::P_W-1:0]            delta_r;
  logic                               renewed_r;
  logic [bca_pkg::P_W-1:0]            base_r;

  logic signed [bca_pkg::DT_W-1:0]    mul_a;
  logic signed [bca_pkg::MB_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]            prod_x;
  logic signed [ACC_W-1:0]            off_x;
  logic signed [ACC_W-1:0]            shr_in;
  int unsigned                        shr_k;
  logic signed [ACC_W-1:0]            shr_out;
  logic signed [ACC_W-1:0]            temp_sum;
  logic signed [ACC_W-1:0]            off_sum;
  logic signed [ACC_W-1:0]            sens_sum;
  logic [ACC_W-1:0]                   cal_off_x;
  logic [ACC_W-1:0]                   cal_sens_x;
  logic [bca_pkg::P_W-1:0]            diff;

  function automatic logic THR_CMP(input logic [bca_pkg::P_W-1:0] d,
                                   input logic [bca_pkg::THR_W-1:0] t);
    return d < t;
  endfunction

  assign prod_x     = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign off_x      = {{(ACC_W-OFF_W){off_r[OFF_W-1]}}, off_r};
  assign cal_off_x  = ACC_W'({cal.offset, {bca_pkg::SH_OFF_CAL{1'b0}}});
  assign cal_sens_x = ACC_W'({cal.sens, {bca_pkg::SH_SENS_CAL{1'b0}}});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      bca_pkg::MUL_DT_C6: begin
        mul_a = dt_r;
        mul_b = $signed({2'b00, cal.temp_coeff});
      end
      bca_pkg::MUL_DT_C4: begin
        mul_a = dt_r;
        mul_b = $signed({2'b00, cal.offset_tc});
      end
      bca_pkg::MUL_DT_C3: begin
        mul_a = dt_r;
        mul_b = $signed({2'b00, cal.sens_tc});
      end
      bca_pkg::MUL_D1_SLO: begin
        mul_a = $signed({2'b00, d1_r});
        mul_b = $signed({1'b0, sens_r[bca_pkg::SH_SENS_HI-1:0]});
      end
      bca_pkg::MUL_D1_SHI: begin
        mul_a = $signed({2'b00, d1_r});
        mul_b = sens_r[bca_pkg::SENS_W-1:bca_pkg::SH_SENS_HI];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared round-toward-zero scaler.
  always_comb begin
    shr_in = prod_x;
    shr_k  = 0;
    case (ctrl.op)
      bca_pkg::OP_TEMP:      shr_k = bca_pkg::SH_TEMP;
      bca_pkg::OP_OFF:       shr_k = bca_pkg::SH_OFF;
      bca_pkg::OP_SENS:      shr_k = bca_pkg::SH_SENS;
      bca_pkg::OP_ACC_SCALE: begin
        shr_in = acc_r;
        shr_k  = bca_pkg::SH_PROD;
      end
      bca_pkg::OP_PRES: begin
        shr_in = acc_r;
        shr_k  = bca_pkg::SH_PRES;
      end
      default: begin
        shr_in = prod_x;
        shr_k  = 0;
      end
    endcase
  end

  assign shr_out  = bca_pkg::trunc_shr(shr_in, shr_k);
  assign temp_sum = ACC_W'(bca_pkg::TEMP_BASE) + shr_out;
  assign off_sum  = $signed(cal_off_x) + shr_out;
  assign sens_sum = $signed(cal_sens_x) + shr_out;
  assign diff     = (p_r > base_r) ? (p_r - base_r) : (base_r - p_r);

  always_ff @(posedge clk) begin
    if (load) begin
      d1_r    <= raw_pressure;
      d2_r    <= raw_temperature;
      req_r   <= zero_request;
      force_r <= zero_force;
    end
    if (ctrl.mul != bca_pkg::MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    case (ctrl.op)
      bca_pkg::OP_DT: begin
        dt_r <= $signed({2'b00, d2_r}) - $signed({2'b00, cal.ref_temp, {bca_pkg::SH_REF{1'b0}}});
      end
      bca_pkg::OP_TEMP: begin
        if (temp_sum < bca_pkg::T_MIN) begin
          temp_r <= bca_pkg::T_W'(bca_pkg::T_MIN);
        end else if (temp_sum > bca_pkg::T_MAX) begin
          temp_r <= bca_pkg::T_W'(bca_pkg::T_MAX);
        end else begin
          temp_r <= temp_sum[bca_pkg::T_W-1:0];
        end
      end
      bca_pkg::OP_OFF:         off_r  <= off_sum[OFF_W-1:0];
      bca_pkg::OP_SENS:        sens_r <= sens_sum[bca_pkg::SENS_W-1:0];
      bca_pkg::OP_ACC_LOAD:    acc_r  <= prod_x;
      bca_pkg::OP_ACC_ADD_HI:  acc_r  <= acc_r + (prod_x <<< bca_pkg::SH_SENS_HI);
      bca_pkg::OP_ACC_SCALE:   acc_r  <= shr_out;
      bca_pkg::OP_ACC_SUB_OFF: acc_r  <= acc_r - off_x;
      bca_pkg::OP_PRES: begin
        if (shr_out < 0) begin
          p_r <= '0;
        end else if (shr_out > bca_pkg::P_MAX) begin
          p_r <= bca_pkg::P_W'(bca_pkg::P_MAX);
        end else begin
          p_r <= shr_out[bca_pkg::P_W-1:0];
        end
      end
      bca_pkg::OP_DIFF: begin
        delta_r   <= diff;
        renewed_r <= 1'b0;
      end
      bca_pkg::OP_ZERO: begin
        if ((THR_CMP(delta_r, cal.thr)) || force_r) begin
          delta_r   <= '0;
          renewed_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The baseline is architectural state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (ctrl.op == bca_pkg::OP_ZERO && (THR_CMP(delta_r, cal.thr) || force_r)) begin
      base_r <= p_r;
    end
  end

  assign req               = req_r;
  assign pressure_pa       = p_r;
  assign temperature_centi = temp_r;
  assign pressure_delta    = delta_r;
  assign baseline_renewed  = renewed_r;

endmodule

`default_nettype wire

// File: design/bca_sequencer.sv
`default_nettype none

module bca_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              req,
  input  wire logic              out_free,
  output bca_pkg::dp_ctrl_t      ctrl,
  output logic                   busy,
  output logic                   done
);

  bca_pkg::seq_state_t             state_r;
  bca_pkg::seq_state_t             state_nxt;
  logic [bca_pkg::STEP_W-1:0]      step_r;
  logic [bca_pkg::STEP_W-1:0]      step_nxt;
  bca_pkg::ucode_t                 cw;

  bca_ucode_rom u_rom (
    .step (step_r),
    .word (cw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bca_pkg::SEQ_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctrl      = '{bca_pkg::OP_NOP, bca_pkg::MUL_NONE};
    done      = 1'b0;
    case (state_r)
      bca_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = bca_pkg::SEQ_RUN;
          step_nxt  = '0;
        end
      end
      bca_pkg::SEQ_RUN: begin
        if (cw.last) begin
          // Hold on the final step until the output register can take the result.
          if (out_free) begin
            done      = 1'b1;
            state_nxt = bca_pkg::SEQ_IDLE;
          end
        end else begin
          ctrl = '{cw.op, cw.mul};
          if (cw.jmp == bca_pkg::JMP_NO_REQ && !req) begin
            step_nxt = cw.target;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = bca_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign busy = (state_r == bca_pkg::SEQ_RUN);

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bca_pkg::*;

  localparam int     IDLE_PCT     = 18;
  localparam int     PHASES       = 5;
  localparam int     PHASE_ITEMS  = 130;
  localparam int     CALM_PHASE   = 3;
  localparam int     DRAIN_GAP    = 20;
  localparam int     MAX_PRINTS   = 40;
  localparam int     RAW_TOP      = (1 << RAW_W) - 1;
  localparam int     TYP_D1       = 9085466;
  localparam int     TYP_D2       = 8569150;
  localparam int     TYP_CAL [6]  = '{40127, 36924, 23317, 23282, 33464, 28312};
  localparam longint RUN_LIMIT_NS = 6000000;

  localparam logic [RAW_W-1:0] RAW_MAX      = '1;
  localparam logic [RAW_W-1:0] TYP_RP       = RAW_W'(TYP_D1);
  localparam logic [RAW_W-1:0] TYP_RT       = RAW_W'(TYP_D2);
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;
  localparam logic [IDX_W-1:0] REG_SPARE    = '1;  // decodes to no register

  localparam longint REF_MUL  = longint'(1) << SH_REF;
  localparam longint TEMP_DIV = longint'(1) << SH_TEMP;
  localparam longint OFF_MUL  = longint'(1) << SH_OFF_CAL;
  localparam longint OFF_DIV  = longint'(1) << SH_OFF;
  localparam longint SENS_MUL = longint'(1) << SH_SENS_CAL;
  localparam longint SENS_DIV = longint'(1) << SH_SENS;
  localparam longint PROD_DIV = longint'(1) << SH_PROD;
  localparam longint PRES_DIV = longint'(1) << SH_PRES;

  typedef struct {
    logic [P_W-1:0]        pres;
    logic signed [T_W-1:0] temp;
    logic [P_W-1:0]        delta;
    logic                  renewed;
  } reading_t;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    logic [RAW_W-1:0] rp;
    logic [RAW_W-1:0] rt;
    logic             req;
    logic             frc;
    bit               known;
    reading_t         want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_W-1:0]      in_raw_pressure;
  logic [RAW_W-1:0]      in_raw_temperature;
  logic                  in_zero_request;
  logic                  in_zero_force;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [P_W-1:0]        out_pressure_pa;
  logic signed [T_W-1:0] out_temperature_centi;
  logic [P_W-1:0]        out_pressure_delta;
  logic                  out_baseline_renewed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  cal_t           cal;
  logic [P_W-1:0] base_pa;
  reading_t       pending[$];
  step_row_t      plan[$];
  int             mismatch_count = 0;
  bit             calm = 1'b0;

  baro_compensate_autozero_unit uut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Compensates one sample and moves the baseline the way the block should.
  function automatic reading_t compensate_sample(input logic [RAW_W-1:0] d1,
                                                 input logic [RAW_W-1:0] d2,
                                                 input logic req, input logic frc);
    longint         raw_p, raw_t, dt, t_c, off, sens, pres;
    logic [P_W-1:0] p, diff;
    reading_t       r;
    raw_p = longint'(d1);
    raw_t = longint'(d2);
    dt    = raw_t - longint'(cal.ref_temp) * REF_MUL;
    t_c   = TEMP_BASE + (dt * longint'(cal.temp_coeff)) / TEMP_DIV;
    off   = longint'(cal.offset) * OFF_MUL + (longint'(cal.offset_tc) * dt) / OFF_DIV;
    sens  = longint'(cal.sens) * SENS_MUL + (longint'(cal.sens_tc) * dt) / SENS_DIV;
    pres  = ((raw_p * sens) / PROD_DIV - off) / PRES_DIV;
    if (pres < 0) begin
      p = '0;
    end else if (pres > P_MAX) begin
      p = P_W'(P_MAX);
    end else begin
      p = pres[P_W-1:0];
    end
    if (t_c < T_MIN) begin
      t_c = longint'(T_MIN);
    end else if (t_c > T_MAX) begin
      t_c = longint'(T_MAX);
    end
    diff      = (p > base_pa) ? p - base_pa : base_pa - p;
    r.pres    = p;
    r.temp    = t_c[T_W-1:0];
    r.delta   = diff;
    r.renewed = 1'b0;
    if (req && (diff < cal.thr || frc)) begin
      base_pa   = p;
      r.delta   = '0;
      r.renewed = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk) begin : result_check
    reading_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        flag_mismatch("result with none outstanding, pressure_pa",
                      longint'(out_pressure_pa), longint'(0));
      end else begin
        w = pending.pop_front();
        check_field("pressure_pa", longint'(out_pressure_pa), longint'(w.pres));
        check_field("temperature_centi", longint'(out_temperature_centi), longint'(w.temp));
        check_field("pressure_delta", longint'(out_pressure_delta), longint'(w.delta));
        check_field("baseline_renewed", longint'(out_baseline_renewed),
                    longint'(w.renewed));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SENS:       cal.sens       = data[CAL_W-1:0];
      REG_OFFSET:     cal.offset     = data[CAL_W-1:0];
      REG_SENS_TC:    cal.sens_tc    = data[CAL_W-1:0];
      REG_OFFSET_TC:  cal.offset_tc  = data[CAL_W-1:0];
      REG_REF_TEMP:   cal.ref_temp   = data[CAL_W-1:0];
      REG_TEMP_COEFF: cal.temp_coeff = data[CAL_W-1:0];
      REG_THRESHOLD:  cal.thr        = data[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
                             input logic req, input logic frc,
                             input bit use_want, input reading_t want);
    reading_t pred;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_raw_pressure    = rp;
    in_raw_temperature = rt;
    in_zero_request    = req;
    in_zero_force      = frc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = compensate_sample(rp, rt, req, frc);
    pending.push_back(use_want ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic plan_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.known  = 1'b0;
    plan.push_back(r);
  endtask

  task automatic plan_item(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
                           input logic req, input logic frc);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.rp     = rp;
    r.rt     = rt;
    r.req    = req;
    r.frc    = frc;
    r.known  = 1'b0;
    plan.push_back(r);
  endtask

  // With every calibration word zero the output is fixed: 0 Pa at 20.00 degrees,
  // and any request lands on the zero baseline.
  task automatic plan_uncal(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
                            input logic req, input logic frc);
    step_row_t r;
    r.is_cfg       = 1'b0;
    r.rp           = rp;
    r.rt           = rt;
    r.req          = req;
    r.frc          = frc;
    r.known        = 1'b1;
    r.want.pres    = '0;
    r.want.temp    = T_W'(TEMP_BASE);
    r.want.delta   = '0;
    r.want.renewed = req;
    plan.push_back(r);
  endtask

  initial begin : stimulus
    reading_t         none_given;
    int               center_p, center_t, d1, d2, jitter, pick, wdata;
    logic [RAW_W-1:0] rp, rt;
    logic             req, frc;

    in_valid           = 1'b0;
    in_raw_pressure    = '0;
    in_raw_temperature = '0;
    in_zero_request    = 1'b0;
    in_zero_force      = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_SENS;
    cfg_data           = '0;
    cal                = '0;
    cal.thr            = THR_RESET;
    base_pa            = '0;
    center_p           = TYP_D1;
    center_t           = TYP_D2;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    plan_uncal('0, '0, 1'b0, 1'b0);
    plan_uncal(RAW_MAX, RAW_MAX, 1'b1, 1'b0);
    plan_uncal(RAW_MAX, '0, 1'b0, 1'b1);
    plan_uncal('0, RAW_MAX, 1'b1, 1'b1);
    // Bit 16 lies above the sensitivity word and must be dropped.
    plan_cfg(REG_SENS, CFG_W'(TYP_CAL[REG_SENS] + (1 << CAL_W)));
    plan_cfg(REG_OFFSET, CFG_W'(TYP_CAL[REG_OFFSET]));
    plan_cfg(REG_SENS_TC, CFG_W'(TYP_CAL[REG_SENS_TC]));
    plan_cfg(REG_OFFSET_TC, CFG_W'(TYP_CAL[REG_OFFSET_TC]));
    plan_cfg(REG_REF_TEMP, CFG_W'(TYP_CAL[REG_REF_TEMP]));
    plan_cfg(REG_TEMP_COEFF, CFG_W'(TYP_CAL[REG_TEMP_COEFF]));
    plan_cfg(REG_SPARE, CFG_ALL_ONES);
    plan_item(TYP_RP, TYP_RT, 1'b0, 1'b0);
    plan_item(TYP_RP, TYP_RT, 1'b1, 1'b0);
    plan_item(TYP_RP, TYP_RT, 1'b1, 1'b1);
    plan_item(RAW_W'(TYP_D1 + 40), TYP_RT, 1'b1, 1'b0);
    plan_item(RAW_W'(TYP_D1 + 200000), TYP_RT, 1'b1, 1'b0);
    plan_item('0, '0, 1'b0, 1'b0);
    plan_item(RAW_MAX, RAW_MAX, 1'b0, 1'b1);
    plan_cfg(REG_THRESHOLD, '0);
    plan_item(TYP_RP, TYP_RT, 1'b1, 1'b0);
    plan_item(TYP_RP, TYP_RT, 1'b1, 1'b1);
    // Baseline at zero, then a full-scale reading sits exactly at the threshold.
    plan_cfg(REG_THRESHOLD, CFG_W'(P_MAX));
    plan_item('0, TYP_RT, 1'b1, 1'b1);
    plan_item(RAW_MAX, TYP_RT, 1'b1, 1'b0);
    plan_item(TYP_RP, TYP_RT, 1'b1, 1'b0);
    for (int i = REG_SENS; i <= REG_TEMP_COEFF; i++) begin
      plan_cfg(IDX_W'(i), CFG_ALL_ONES);
    end
    plan_item(RAW_MAX, RAW_MAX, 1'b0, 1'b0);
    plan_item('0, '0, 1'b0, 1'b0);
    plan_item(RAW_MAX, '0, 1'b1, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_cal(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].rp, plan[i].rt, plan[i].req, plan[i].frc,
                    plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      calm = (ph == CALM_PHASE);
      for (int i = REG_SENS; i <= REG_TEMP_COEFF; i++) begin
        case (ph % 3)
          0: wdata = TYP_CAL[i] ^ int'($urandom_range(1023));
          1: wdata = $urandom();
          default: begin
            pick  = $urandom_range(2);
            wdata = (pick == 0) ? 0 : (pick == 1) ? int'(CFG_ALL_ONES) : $urandom();
          end
        endcase
        write_cal(IDX_W'(i), CFG_W'(wdata));
      end
      case (ph % 3)
        0: wdata = $urandom_range(3000);
        1: begin
          wdata = $urandom();
          write_cal(REG_SPARE, CFG_W'($urandom()));
        end
        default: begin
          pick  = $urandom_range(2);
          wdata = (pick == 0) ? 0 : (pick == 1) ? P_MAX : $urandom_range(5000);
        end
      endcase
      write_cal(REG_THRESHOLD, CFG_W'(wdata));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          if (ph % 3 == 0) begin
            center_p = TYP_D1 + $urandom_range(1 << 21) - (1 << 20);
            center_t = TYP_D2 + $urandom_range(1 << 21) - (1 << 20);
          end else begin
            center_p = $urandom_range(RAW_TOP);
            center_t = $urandom_range(RAW_TOP);
          end
        end
        // Hold the sender until the block has returned everything.
        if (ph == 0 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
          jitter = 1 << $urandom_range(14);
          d1     = center_p + $urandom_range(2 * jitter) - jitter;
          d2     = center_t + $urandom_range(64) - 32;
        end else if (pick < 85) begin
          d1 = $urandom_range(RAW_TOP);
          d2 = $urandom_range(RAW_TOP);
        end else begin
          d1 = $urandom_range(1) ? RAW_TOP : 0;
          d2 = $urandom_range(2) == 0 ? 0 : $urandom_range(1) ? RAW_TOP : $urandom_range(RAW_TOP);
        end
        rp  = (d1 < 0) ? '0 : (d1 > RAW_TOP) ? RAW_MAX : RAW_W'(d1);
        rt  = (d2 < 0) ? '0 : (d2 > RAW_TOP) ? RAW_MAX : RAW_W'(d2);
        req = $urandom_range(99) < 40;
        frc = $urandom_range(99) < 25;
        send_sample(rp, rt, req, frc, 1'b0, none_given);
      end
    end
    calm = 1'b0;

    drain_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
design/bca_pkg.sv
design/bca_ucode_rom.sv
design/bca_datapath.sv
design/bca_sequencer.sv
design/baro_compensate_autozero_unit.sv
tb/tb_top.sv
